@@ design/apjb_pkg.sv @@
// Shared types, constants and the saturating increment helper of the audio packet jitter buffer.
`timescale 1ns / 1ps

package apjb_pkg;

  localparam int CAPACITY = 32;
  localparam int SEQ_BITS = 16;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W    = 32;
  localparam int NUM_CNT  = 5;

  localparam int CNT_WRONG = 0;
  localparam int CNT_LATE  = 1;
  localparam int CNT_DUP   = 2;
  localparam int CNT_OVER  = 3;
  localparam int CNT_LOSS  = 4;

  localparam logic [1:0] CFG_OWN_STREAM      = 2'd0;
  localparam logic [1:0] CFG_CAPACITY_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_START_THRESHOLD = 2'd2;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [15:0]         payload_t;
  typedef logic [CAPACITY-1:0] entry_vec_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_CONSUME  = 3'd1,
    MODE_CONCEAL  = 3'd2,
    MODE_REBUFFER = 3'd3,
    MODE_RESTART  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    DISP_ACCEPTED     = 3'd0,
    DISP_WRONG_STREAM = 3'd1,
    DISP_LATE         = 3'd2,
    DISP_DUPLICATE    = 3'd3,
    DISP_OVERFLOW     = 3'd4,
    DISP_NONE         = 3'd5
  } disp_t;

  typedef enum logic [1:0] {
    PLAY_BUFFERING = 2'd0,
    PLAY_PLAYING   = 2'd1,
    PLAY_REBUFFER  = 2'd2
  } play_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] stream;
    logic [15:0] seq;
    payload_t    payload;
  } item_t;

  typedef struct packed {
    logic [31:0] own_stream;
    logic [5:0]  capacity_limit;
    logic [5:0]  start_threshold;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic       clear_all;
    entry_vec_t wr_oh;
    seq_t       wr_seq;
    payload_t   wr_payload;
    entry_vec_t inv_oh;
  } store_cmd_t;

  typedef struct packed {
    logic       hit;
    entry_vec_t hit_oh;
    payload_t   hit_payload;
    entry_vec_t free_oh;
  } store_look_t;

  typedef struct packed {
    disp_t       disposition;
    logic        packet_valid;
    logic [15:0] out_seq;
    payload_t    out_payload;
    play_t       play;
    logic [5:0]  fill;
    cnt_t        wrong;
    cnt_t        late;
    cnt_t        dup;
    cnt_t        over;
    cnt_t        loss;
  } result_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

@@ design/apjb_store.sv @@
// Associative packet store with parallel sequence match and free slot search.
`timescale 1ns / 1ps

module apjb_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apjb_pkg::seq_t       key,
  input  apjb_pkg::store_cmd_t cmd,
  output apjb_pkg::store_look_t look
);

  apjb_pkg::entry_vec_t valid_r;
  apjb_pkg::entry_vec_t valid_nxt;
  apjb_pkg::seq_t       seq_r [apjb_pkg::CAPACITY];
  apjb_pkg::payload_t   pay_r [apjb_pkg::CAPACITY];

  always_comb begin
    look.hit_oh      = '0;
    look.hit_payload = '0;
    for (int i = 0; i < apjb_pkg::CAPACITY; i++) begin
      look.hit_oh[i]   = valid_r[i] && (seq_r[i] == key);
      look.hit_payload = look.hit_payload | (pay_r[i] & {16{look.hit_oh[i]}});
    end
    look.hit     = |look.hit_oh;
    look.free_oh = ~valid_r & (valid_r + apjb_pkg::entry_vec_t'(1));
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.en) begin
      if (cmd.clear_all) begin
        valid_nxt = '0;
      end else begin
        valid_nxt = (valid_r & ~cmd.inv_oh) | cmd.wr_oh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < apjb_pkg::CAPACITY; i++) begin
      if (cmd.en && !cmd.clear_all && cmd.wr_oh[i]) begin
        seq_r[i] <= cmd.wr_seq;
        pay_r[i] <= cmd.wr_payload;
      end
    end
  end

endmodule

@@ design/apjb_engine.sv @@
// Decision logic, playback state, expected sequence and saturating event counters.
`timescale 1ns / 1ps

module apjb_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  apjb_pkg::item_t       item,
  input  apjb_pkg::cfg_t        cfg,
  input  apjb_pkg::store_look_t look,
  output apjb_pkg::seq_t        key,
  output apjb_pkg::store_cmd_t  cmd,
  output apjb_pkg::result_t     result
);

  apjb_pkg::fill_t held_r, held_nxt;
  logic            known_r, known_nxt;
  apjb_pkg::seq_t  expected_r, expected_nxt;
  apjb_pkg::play_t play_r, play_nxt;
  apjb_pkg::cnt_t  cnt_r [apjb_pkg::NUM_CNT];
  apjb_pkg::cnt_t  cnt_nxt [apjb_pkg::NUM_CNT];

  apjb_pkg::seq_t  item_seq;
  apjb_pkg::seq_t  diff;
  logic            over_full;
  logic            thr_met;
  logic            can_play;

  assign item_seq  = apjb_pkg::SEQ_BITS'(item.seq);
  assign diff      = item_seq - expected_r;
  assign key       = (item.mode == apjb_pkg::MODE_INSERT) ? item_seq : expected_r;
  assign over_full = (32'(held_r) >= 32'(cfg.capacity_limit)) ||
                     (32'(held_r) >= apjb_pkg::CAPACITY);
  assign thr_met   = (32'(held_r) + 32'd1) >= 32'(cfg.start_threshold);
  assign can_play  = (play_r == apjb_pkg::PLAY_PLAYING) && known_r;

  always_comb begin
    held_nxt     = held_r;
    known_nxt    = known_r;
    expected_nxt = expected_r;
    play_nxt     = play_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.en       = step;
    result       = '0;
    result.disposition = apjb_pkg::DISP_NONE;
    unique case (item.mode)
      apjb_pkg::MODE_INSERT: begin
        if (item.stream != cfg.own_stream) begin
          result.disposition = apjb_pkg::DISP_WRONG_STREAM;
          cnt_nxt[apjb_pkg::CNT_WRONG] = apjb_pkg::sat_inc(cnt_r[apjb_pkg::CNT_WRONG]);
        end else if (known_r && (diff != '0) && diff[apjb_pkg::SEQ_BITS-1]) begin
          result.disposition = apjb_pkg::DISP_LATE;
          cnt_nxt[apjb_pkg::CNT_LATE] = apjb_pkg::sat_inc(cnt_r[apjb_pkg::CNT_LATE]);
        end else if (look.hit) begin
          result.disposition = apjb_pkg::DISP_DUPLICATE;
          cnt_nxt[apjb_pkg::CNT_DUP] = apjb_pkg::sat_inc(cnt_r[apjb_pkg::CNT_DUP]);
        end else if (over_full) begin
          result.disposition = apjb_pkg::DISP_OVERFLOW;
          cnt_nxt[apjb_pkg::CNT_OVER] = apjb_pkg::sat_inc(cnt_r[apjb_pkg::CNT_OVER]);
        end else begin
          result.disposition = apjb_pkg::DISP_ACCEPTED;
          cmd.wr_oh      = look.free_oh;
          cmd.wr_seq     = item_seq;
          cmd.wr_payload = item.payload;
          held_nxt       = held_r + apjb_pkg::fill_t'(1);
          if (!known_r) begin
            known_nxt    = 1'b1;
            expected_nxt = item_seq;
          end
          if (thr_met) begin
            play_nxt = apjb_pkg::PLAY_PLAYING;
          end
        end
      end
      apjb_pkg::MODE_CONSUME: begin
        if (can_play && look.hit) begin
          result.packet_valid = 1'b1;
          result.out_seq      = 16'(expected_r);
          result.out_payload  = look.hit_payload;
          cmd.inv_oh          = look.hit_oh;
          held_nxt            = held_r - apjb_pkg::fill_t'(1);
          expected_nxt        = expected_r + apjb_pkg::seq_t'(1);
        end
      end
      apjb_pkg::MODE_CONCEAL: begin
        if (can_play) begin
          if (look.hit) begin
            cmd.inv_oh = look.hit_oh;
            held_nxt   = held_r - apjb_pkg::fill_t'(1);
          end
          expected_nxt = expected_r + apjb_pkg::seq_t'(1);
          cnt_nxt[apjb_pkg::CNT_LOSS] = apjb_pkg::sat_inc(cnt_r[apjb_pkg::CNT_LOSS]);
        end
      end
      apjb_pkg::MODE_REBUFFER: begin
        cmd.clear_all = 1'b1;
        held_nxt      = '0;
        known_nxt     = 1'b0;
        expected_nxt  = '0;
        play_nxt      = apjb_pkg::PLAY_REBUFFER;
      end
      apjb_pkg::MODE_RESTART: begin
        cmd.clear_all = 1'b1;
        held_nxt      = '0;
        known_nxt     = 1'b0;
        expected_nxt  = '0;
        play_nxt      = apjb_pkg::PLAY_BUFFERING;
        for (int i = 0; i < apjb_pkg::NUM_CNT; i++) begin
          cnt_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
    result.play  = play_nxt;
    result.fill  = 6'(held_nxt);
    result.wrong = cnt_nxt[apjb_pkg::CNT_WRONG];
    result.late  = cnt_nxt[apjb_pkg::CNT_LATE];
    result.dup   = cnt_nxt[apjb_pkg::CNT_DUP];
    result.over  = cnt_nxt[apjb_pkg::CNT_OVER];
    result.loss  = cnt_nxt[apjb_pkg::CNT_LOSS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      known_r    <= 1'b0;
      expected_r <= '0;
      play_r     <= apjb_pkg::PLAY_BUFFERING;
      for (int i = 0; i < apjb_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      held_r     <= held_nxt;
      known_r    <= known_nxt;
      expected_r <= expected_nxt;
      play_r     <= play_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

@@ design/audio_packet_jitter_buffer_top.sv @@
// Top level of the audio packet jitter buffer: handshakes, configuration and result register.
`timescale 1ns / 1ps

// The input channel carries one operation per transfer: insert, consume, conceal,
// silent rebuffer or restart, with the packet's stream, sequence and payload handle.
// The result channel returns exactly one result per input transfer, in order.
// Configuration registers are written over the cfg channel, which is always ready,
// and are meant to be written only while no item is in flight.
// An accepted item is held in an input register; once the output register is free or
// being emptied, the packet store is matched against all entries at once and the
// result is written to the output register.
// Throughput is one item per cycle while out_ready stays high, as the parallel match is combinational.
// While a result waits because out_ready is low, one more item is still taken into
// the input register; after that in_ready stays low until the result is taken.
// Reset empties the store, clears the counters and sets the configuration to
// stream 1, capacity 32 and start threshold 4; no clearing pass follows reset.
module audio_packet_jitter_buffer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_pkt_stream,
  input  logic [15:0] in_pkt_sequence,
  input  logic [15:0] in_pkt_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_disposition,
  output logic        out_packet_valid,
  output logic [15:0] out_sequence,
  output logic [15:0] out_payload,
  output logic [1:0]  out_playback_state,
  output logic [5:0]  out_fill_level,
  output logic [31:0] out_wrong_stream_count,
  output logic [31:0] out_late_count,
  output logic [31:0] out_duplicate_count,
  output logic [31:0] out_overflow_count,
  output logic [31:0] out_loss_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic                  s1_valid_r;
  apjb_pkg::item_t       item_r;
  logic                  out_valid_r;
  apjb_pkg::result_t     res_r;
  apjb_pkg::cfg_t        cfg_r;
  apjb_pkg::result_t     result;
  apjb_pkg::store_cmd_t  cmd;
  apjb_pkg::store_look_t look;
  apjb_pkg::seq_t        key;
  logic                  step;

  assign step      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode    <= in_mode;
      item_r.stream  <= in_pkt_stream;
      item_r.seq     <= in_pkt_sequence;
      item_r.payload <= in_pkt_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_stream      <= 32'd1;
      cfg_r.capacity_limit  <= 6'd32;
      cfg_r.start_threshold <= 6'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        apjb_pkg::CFG_OWN_STREAM:      cfg_r.own_stream      <= cfg_data;
        apjb_pkg::CFG_CAPACITY_LIMIT:  cfg_r.capacity_limit  <= cfg_data[5:0];
        apjb_pkg::CFG_START_THRESHOLD: cfg_r.start_threshold <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  apjb_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key),
    .cmd   (cmd),
    .look  (look)
  );

  apjb_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg_r),
    .look   (look),
    .key    (key),
    .cmd    (cmd),
    .result (result)
  );

  assign out_valid              = out_valid_r;
  assign out_disposition        = res_r.disposition;
  assign out_packet_valid       = res_r.packet_valid;
  assign out_sequence           = res_r.out_seq;
  assign out_payload            = res_r.out_payload;
  assign out_playback_state     = res_r.play;
  assign out_fill_level         = res_r.fill;
  assign out_wrong_stream_count = res_r.wrong;
  assign out_late_count         = res_r.late;
  assign out_duplicate_count    = res_r.dup;
  assign out_overflow_count     = res_r.over;
  assign out_loss_count         = res_r.loss;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage was free");

  a_non_insert_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (item_r.mode != apjb_pkg::MODE_INSERT))
      |=> (out_disposition == apjb_pkg::DISP_NONE))
    else $error("non-insert item reported an insert disposition");

  a_delivery_while_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_packet_valid)
      |-> (out_playback_state == apjb_pkg::PLAY_PLAYING))
    else $error("packet delivered outside playback");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (item_r.mode == apjb_pkg::MODE_RESTART))
      |=> (out_valid && (out_fill_level == 6'd0) && (out_loss_count == 32'd0) &&
           (out_wrong_stream_count == 32'd0)))
    else $error("restart left state behind");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the audio packet jitter buffer top level.
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [31:0] in_pkt_stream;
  logic [15:0] in_pkt_sequence;
  logic [15:0] in_pkt_payload;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_disposition;
  logic        out_packet_valid;
  logic [15:0] out_sequence;
  logic [15:0] out_payload;
  logic [1:0]  out_playback_state;
  logic [5:0]  out_fill_level;
  logic [31:0] out_wrong_stream_count;
  logic [31:0] out_late_count;
  logic [31:0] out_duplicate_count;
  logic [31:0] out_overflow_count;
  logic [31:0] out_loss_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  audio_packet_jitter_buffer_top u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_mode                (in_mode),
    .in_pkt_stream          (in_pkt_stream),
    .in_pkt_sequence        (in_pkt_sequence),
    .in_pkt_payload         (in_pkt_payload),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_disposition        (out_disposition),
    .out_packet_valid       (out_packet_valid),
    .out_sequence           (out_sequence),
    .out_payload            (out_payload),
    .out_playback_state     (out_playback_state),
    .out_fill_level         (out_fill_level),
    .out_wrong_stream_count (out_wrong_stream_count),
    .out_late_count         (out_late_count),
    .out_duplicate_count    (out_duplicate_count),
    .out_overflow_count     (out_overflow_count),
    .out_loss_count         (out_loss_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #5 clk = ~clk;

  logic [31:0]       acc_stream;
  logic [5:0]        acc_cap;
  logic [5:0]        acc_thresh;
  logic              slot_used [apjb_pkg::CAPACITY];
  apjb_pkg::seq_t    slot_seq [apjb_pkg::CAPACITY];
  apjb_pkg::payload_t slot_pay [apjb_pkg::CAPACITY];
  int                held;
  logic              seq_known;
  apjb_pkg::seq_t    next_seq;
  apjb_pkg::play_t   play;
  apjb_pkg::cnt_t    tally [apjb_pkg::NUM_CNT];

  apjb_pkg::result_t pending_results [$];
  int                err_cnt = 0;
  int                idle_cycles = 0;
  apjb_pkg::seq_t    gen_head;
  bit                tx_gaps_on = 1'b1;
  bit                rx_stalls_on = 1'b1;
  int                rx_hold_cycles = 0;

  function automatic void drop_store();
    for (int i = 0; i < apjb_pkg::CAPACITY; i++) slot_used[i] = 1'b0;
    held = 0;
    seq_known = 1'b0;
    next_seq = '0;
  endfunction

  function automatic void buffer_reset();
    acc_stream = 32'd1;
    acc_cap = 6'd32;
    acc_thresh = 6'd4;
    drop_store();
    play = apjb_pkg::PLAY_BUFFERING;
    for (int i = 0; i < apjb_pkg::NUM_CNT; i++) tally[i] = '0;
  endfunction

  function automatic void bump(int which);
    if (tally[which] != '1) tally[which] = tally[which] + 1'b1;
  endfunction

  function automatic int find_slot(apjb_pkg::seq_t sq);
    for (int i = 0; i < apjb_pkg::CAPACITY; i++)
      if (slot_used[i] && slot_seq[i] == sq) return i;
    return -1;
  endfunction

  function automatic apjb_pkg::disp_t place_packet(logic [31:0] stream, apjb_pkg::seq_t sq,
                                                   apjb_pkg::payload_t pay);
    apjb_pkg::seq_t ahead;
    int             room;
    ahead = sq - next_seq;
    room = (acc_cap < apjb_pkg::CAPACITY) ? int'(acc_cap) : apjb_pkg::CAPACITY;
    if (stream != acc_stream) begin
      bump(apjb_pkg::CNT_WRONG);
      return apjb_pkg::DISP_WRONG_STREAM;
    end
    if (seq_known && ahead != '0 && ahead[apjb_pkg::SEQ_BITS-1]) begin
      bump(apjb_pkg::CNT_LATE);
      return apjb_pkg::DISP_LATE;
    end
    if (find_slot(sq) >= 0) begin
      bump(apjb_pkg::CNT_DUP);
      return apjb_pkg::DISP_DUPLICATE;
    end
    if (held >= room) begin
      bump(apjb_pkg::CNT_OVER);
      return apjb_pkg::DISP_OVERFLOW;
    end
    for (int i = 0; i < apjb_pkg::CAPACITY; i++) begin
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_seq[i] = sq;
        slot_pay[i] = pay;
        held++;
        break;
      end
    end
    if (!seq_known) begin
      seq_known = 1'b1;
      next_seq = sq;
    end
    if (held >= int'(acc_thresh)) play = apjb_pkg::PLAY_PLAYING;
    return apjb_pkg::DISP_ACCEPTED;
  endfunction

  function automatic apjb_pkg::result_t buffer_step(logic [2:0] mode, logic [31:0] stream,
                                                    apjb_pkg::seq_t sq,
                                                    apjb_pkg::payload_t pay);
    apjb_pkg::result_t res;
    int                k;
    res = '0;
    res.disposition = apjb_pkg::DISP_NONE;
    case (mode)
      apjb_pkg::MODE_INSERT: begin
        res.disposition = place_packet(stream, sq, pay);
      end
      apjb_pkg::MODE_CONSUME: begin
        if (play == apjb_pkg::PLAY_PLAYING && seq_known) begin
          k = find_slot(next_seq);
          if (k >= 0) begin
            res.packet_valid = 1'b1;
            res.out_seq = slot_seq[k];
            res.out_payload = slot_pay[k];
            slot_used[k] = 1'b0;
            held--;
            next_seq = next_seq + 1'b1;
          end
        end
      end
      apjb_pkg::MODE_CONCEAL: begin
        if (play == apjb_pkg::PLAY_PLAYING && seq_known) begin
          k = find_slot(next_seq);
          if (k >= 0) begin
            slot_used[k] = 1'b0;
            held--;
          end
          next_seq = next_seq + 1'b1;
          bump(apjb_pkg::CNT_LOSS);
        end
      end
      apjb_pkg::MODE_REBUFFER: begin
        drop_store();
        play = apjb_pkg::PLAY_REBUFFER;
      end
      apjb_pkg::MODE_RESTART: begin
        drop_store();
        play = apjb_pkg::PLAY_BUFFERING;
        for (int i = 0; i < apjb_pkg::NUM_CNT; i++) tally[i] = '0;
      end
      default: ;
    endcase
    res.play = play;
    res.fill = 6'(held);
    res.wrong = tally[apjb_pkg::CNT_WRONG];
    res.late = tally[apjb_pkg::CNT_LATE];
    res.dup = tally[apjb_pkg::CNT_DUP];
    res.over = tally[apjb_pkg::CNT_OVER];
    res.loss = tally[apjb_pkg::CNT_LOSS];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    apjb_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t ns: result expected none actual disposition %0h", $time,
                     out_disposition);
        end else begin
          want = pending_results.pop_front();
          check_field("disposition", 32'(want.disposition), 32'(out_disposition));
          check_field("packet_valid", 32'(want.packet_valid), 32'(out_packet_valid));
          check_field("sequence", 32'(want.out_seq), 32'(out_sequence));
          check_field("payload", 32'(want.out_payload), 32'(out_payload));
          check_field("playback_state", 32'(want.play), 32'(out_playback_state));
          check_field("fill_level", 32'(want.fill), 32'(out_fill_level));
          check_field("wrong_stream_count", want.wrong, out_wrong_stream_count);
          check_field("late_count", want.late, out_late_count);
          check_field("duplicate_count", want.dup, out_duplicate_count);
          check_field("overflow_count", want.over, out_overflow_count);
          check_field("loss_count", want.loss, out_loss_count);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          apjb_pkg::CFG_OWN_STREAM:      acc_stream = cfg_data;
          apjb_pkg::CFG_CAPACITY_LIMIT:  acc_cap = cfg_data[5:0];
          apjb_pkg::CFG_START_THRESHOLD: acc_thresh = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_results.push_back(buffer_step(in_mode, in_pkt_stream, in_pkt_sequence,
                                              in_pkt_payload));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("audio_packet_jitter_buffer_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [2:0] mode, input logic [31:0] stream,
                           input apjb_pkg::seq_t sq, input apjb_pkg::payload_t pay);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_pkt_stream <= stream;
    in_pkt_sequence <= sq;
    in_pkt_payload <= pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] stream, input logic [5:0] cap,
                            input logic [5:0] thresh);
    wait_drained();
    write_reg(apjb_pkg::CFG_OWN_STREAM, stream);
    write_reg(apjb_pkg::CFG_CAPACITY_LIMIT, {26'($urandom), cap});
    write_reg(apjb_pkg::CFG_START_THRESHOLD, {26'($urandom), thresh});
  endtask

  // Mostly near-in-order packets with jitter, interleaved with playout; the rest is
  // late, foreign, far-off or unused-mode traffic plus occasional flushes.
  task automatic run_traffic(input int count);
    int             r;
    apjb_pkg::seq_t sq;
    logic [31:0]    st;
    logic [2:0]     md;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      st = acc_stream;
      sq = gen_head;
      md = apjb_pkg::MODE_INSERT;
      if (r < 44) begin
        sq = gen_head + apjb_pkg::seq_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) gen_head = gen_head + 1'b1;
      end else if (r < 47) begin
        sq = gen_head - apjb_pkg::seq_t'($urandom_range(40, 32000));
      end else if (r < 50) begin
        st = ($urandom_range(0, 1) == 0) ? $urandom
                                         : acc_stream ^ (32'h1 << $urandom_range(0, 31));
      end else if (r < 52) begin
        sq = apjb_pkg::seq_t'($urandom);
      end else if (r < 84) begin
        md = apjb_pkg::MODE_CONSUME;
      end else if (r < 92) begin
        md = apjb_pkg::MODE_CONCEAL;
      end else if (r < 94) begin
        md = apjb_pkg::MODE_REBUFFER;
      end else if (r < 95) begin
        md = apjb_pkg::MODE_RESTART;
      end else if (r < 97) begin
        md = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        st = $urandom;
        sq = apjb_pkg::seq_t'($urandom);
      end else begin
        md = apjb_pkg::MODE_CONSUME;
        st = $urandom;
        sq = apjb_pkg::seq_t'($urandom);
      end
      send_item(md, st, sq, apjb_pkg::payload_t'($urandom));
    end
  endtask

  task automatic test_directed_ops();
    send_item(apjb_pkg::MODE_CONSUME, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_CONCEAL, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_INSERT, 32'h0000_0000, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'hFFFE, 16'hFFFF);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'hFFFE, 16'h1234);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'h7FFE, 16'h0000);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'h7FFD, 16'hABCD);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'hFFFF, 16'h5555);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'h0000, 16'hAAAA);
    send_item(apjb_pkg::MODE_CONSUME, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_CONSUME, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_CONCEAL, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_CONCEAL, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_CONSUME, 32'd1, 16'h0000, 16'h0000);
    send_item(MODE_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_item(MODE_SPARE_LO, 32'd1, 16'h0001, 16'h0001);
    send_item(apjb_pkg::MODE_REBUFFER, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_INSERT, 32'd1, 16'h0010, 16'h0F0F);
    send_item(apjb_pkg::MODE_RESTART, 32'd1, 16'h0000, 16'h0000);
    send_item(apjb_pkg::MODE_CONSUME, 32'd1, 16'h0000, 16'h0000);
  endtask

  task automatic test_config_sweep();
    set_config(32'hFFFF_FFFF, 6'd1, 6'd1);
    run_traffic(80);
    set_config($urandom, 6'd0, 6'd0);
    run_traffic(40);
    set_config($urandom, 6'd8, 6'd0);
    run_traffic(80);
    set_config($urandom, 6'd63, 6'd63);
    run_traffic(100);
    set_config($urandom, 6'd32, 6'd32);
    run_traffic(120);
    set_config($urandom, 6'd12, 6'd20);
    run_traffic(80);
  endtask

  task automatic test_output_backpressure();
    set_config($urandom, 6'd32, 6'd4);
    run_traffic(20);
    rx_hold_cycles = 150;
    run_traffic(80);
  endtask

  task automatic test_sender_drain_pause();
    run_traffic(40);
    wait_drained();
    run_traffic(40);
  endtask

  task automatic test_steady_stream();
    set_config(32'd1, 6'd16, 6'd3);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    run_traffic(350);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= apjb_pkg::MODE_INSERT;
    in_pkt_stream <= '0;
    in_pkt_sequence <= '0;
    in_pkt_payload <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= apjb_pkg::CFG_OWN_STREAM;
    cfg_data <= '0;
    buffer_reset();
    gen_head = apjb_pkg::seq_t'($urandom);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_config_sweep();
    test_output_backpressure();
    test_sender_drain_pause();
    test_steady_stream();
    wait_drained();
    if (err_cnt == 0) begin
      $display("audio_packet_jitter_buffer_top: match");
    end else begin
      $display("audio_packet_jitter_buffer_top: mismatch");
    end
    $finish;
  end

endmodule
